/* src/pha_pkg.sv */
// pha_pkg: types and constants of the per-host byte accounting block.
// Shared by the top level; depends on nothing.

package pha_pkg;

   // item modes
   localparam logic MODE_COUNT  = 1'b0;
   localparam logic MODE_REPORT = 1'b1;

   // packet qualification
   localparam logic [15:0] IPV4_TYPE   = 16'h0800;
   localparam logic [15:0] MIN_FRAME   = 16'd34;
   localparam logic [15:0] OFFSET_MASK = 16'h1fff;

   // host octets that are never reported
   localparam logic [7:0] HOST_NET   = 8'h00;
   localparam logic [7:0] HOST_BCAST = 8'hff;

   // register reset value
   localparam logic [7:0] BASE_RESET = 8'd60;

   localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;

   typedef struct packed {
      logic        mode;
      logic [15:0] eth_proto;
      logic [15:0] frame_length;
      logic [15:0] frag_field;
      logic [15:0] ip_total_length;
      logic [7:0]  src_third_octet;
      logic [7:0]  src_fourth_octet;
      logic [2:0]  report_group;
   } req_type;

   typedef struct packed {
      logic [7:0]  host_third_octet;
      logic [7:0]  host_fourth_octet;
      logic [31:0] byte_count;
      logic        last;
   } rsp_type;

endpackage

/* src/pha_ram.sv */
// pha_ram: generic single-clock RAM, one write port, one read port.
// Read data is registered; no dependencies.

module pha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/per_host_byte_accounting.sv */
// per_host_byte_accounting: per-host byte counters of a /23 subnet in one table RAM.
// Packet: when counted, accept, table read, then saturating add and write; if dropped, accept only.
// Report: accept, then read and check per scanned entry, then a final step; longer while rsp stalls.
// One item at a time; the table read-modify-write through the RAM sets the rate.
// After reset a clearing pass writes zero to all TABLE_ENTRIES entries, one per cycle,
// with req_ready low; csr writes are taken throughout.

module per_host_byte_accounting #(
   parameter int TABLE_ENTRIES = 512,
   parameter int GROUP_SIZE    = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pha_pkg::req_type  req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pha_pkg::rsp_type  rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int IW = ((AW > 9) ? AW : 9) + 1;
   localparam int KW = $clog2(GROUP_SIZE);

   localparam logic [IW-1:0] TABLE_END = IW'(TABLE_ENTRIES);
   localparam logic [IW-1:0] GROUP_LEN = IW'(GROUP_SIZE);
   localparam logic [KW-1:0] K_LAST    = KW'(GROUP_SIZE - 1);
   localparam logic [AW-1:0] CLR_LAST  = AW'(TABLE_ENTRIES - 1);

   // controller states
   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_PRD  = 3'd2;
   localparam logic [2:0] ST_PWR  = 3'd3;
   localparam logic [2:0] ST_SRD  = 3'd4;
   localparam logic [2:0] ST_SCHK = 3'd5;
   localparam logic [2:0] ST_SFIN = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [7:0]       base_ff, base_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [15:0]      tlen_ff, tlen_in;
   logic             pend_valid_ff, pend_valid_in;
   pha_pkg::rsp_type pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pha_pkg::rsp_type rsp_ff, rsp_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [31:0]      wr_data;
   logic             rd_en;
   logic [31:0]      rd_data;

   logic             req_beat;
   logic             counted;
   logic [IW-1:0]    pkt_idx;
   logic [IW-1:0]    pkt_idx_mod;
   logic [32:0]      sum;
   logic [7:0]       host;
   logic             hit;
   logic             rsp_free;

   // table memory
   pha_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (AW'(idx_ff)),
      .rd_data (rd_data)
   );

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // packet qualification and table index, folded into the table size
   assign counted = (req_item.eth_proto == pha_pkg::IPV4_TYPE)
                 && (req_item.frame_length >= pha_pkg::MIN_FRAME)
                 && ((req_item.frag_field & pha_pkg::OFFSET_MASK) == 16'd0);
   assign pkt_idx = IW'({req_item.src_third_octet[0], req_item.src_fourth_octet});
   assign pkt_idx_mod = (pkt_idx >= TABLE_END) ? (pkt_idx - TABLE_END) : pkt_idx;

   // saturating add and scan test
   assign sum  = {1'b0, rd_data} + 33'(tlen_ff);
   assign host = idx_ff[7:0];
   assign hit  = (host != pha_pkg::HOST_NET) && (host != pha_pkg::HOST_BCAST)
              && (rd_data != 32'd0);

   // controller
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      base_in       = base_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      tlen_in       = tlen_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(idx_ff);
      wr_data       = 32'd0;
      rd_en         = 1'b0;

      if (csr_valid) begin
         base_in = csr_data;
      end

      unique case (state_ff)
         ST_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               tlen_in = req_item.ip_total_length;
               k_in    = '0;
               if (req_item.mode == pha_pkg::MODE_REPORT) begin
                  idx_in   = IW'(req_item.report_group) * GROUP_LEN;
                  state_in = ST_SRD;
               end else if (counted) begin
                  idx_in   = pkt_idx_mod;
                  state_in = ST_PRD;
               end
            end
         end
         ST_PRD: begin
            rd_en    = 1'b1;
            state_in = ST_PWR;
         end
         ST_PWR: begin
            wr_en    = 1'b1;
            wr_data  = sum[32] ? pha_pkg::COUNT_MAX : sum[31:0];
            state_in = ST_IDLE;
         end
         ST_SRD: begin
            if (idx_ff >= TABLE_END) begin
               state_in = ST_SFIN;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_SCHK;
            end
         end
         ST_SCHK: begin
            // a new hit pushes the held one out, so wait for the output register
            if (!(hit && pend_valid_ff && !rsp_free)) begin
               if (hit) begin
                  wr_en = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_in       = pend_ff;
                     rsp_valid_in = 1'b1;
                  end
                  pend_valid_in             = 1'b1;
                  pend_in.host_third_octet  = base_ff + 8'(idx_ff >> 8);
                  pend_in.host_fourth_octet = host;
                  pend_in.byte_count        = rd_data;
                  pend_in.last              = 1'b0;
               end
               if (k_ff == K_LAST) begin
                  state_in = ST_SFIN;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  k_in     = k_ff + KW'(1);
                  state_in = ST_SRD;
               end
            end
         end
         ST_SFIN: begin
            // final held beat carries last
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLR;
         clr_ff        <= '0;
         base_ff       <= pha_pkg::BASE_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         base_ff       <= base_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      k_ff    <= k_in;
      tlen_ff <= tlen_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

endmodule
